@@ design/cpic_pkg.sv @@
// shared types, constants and token helpers for the position identifier compare block
`timescale 1ns / 1ps
package cpic_pkg;

  localparam int MaxLevels = 10;
  localparam int UidBits   = 6;
  localparam int KeyW      = 55;
  localparam int UidW      = 60;
  localparam int DepthW    = 4;
  localparam int OrderW    = 11;
  localparam int TokW      = MaxLevels;

  // one input transaction
  typedef struct packed {
    logic [KeyW-1:0]   left_keys;
    logic [UidW-1:0]   left_uids;
    logic [DepthW-1:0] left_depth;
    logic [KeyW-1:0]   right_keys;
    logic [UidW-1:0]   right_uids;
    logic [DepthW-1:0] right_depth;
  } cpic_req_t;

  // one result transaction
  typedef struct packed {
    logic signed [OrderW-1:0] order;
    logic                     same;
  } cpic_res_t;

  // what one lane found at its level
  typedef struct packed {
    logic                     hit;
    logic signed [OrderW-1:0] diff;
  } cpic_lane_t;

  // key token of a level (1-based): lvl bits starting at lvl*(lvl-1)/2
  function automatic logic [TokW-1:0] key_token(logic [KeyW-1:0] keys, int lvl);
    logic [KeyW-1:0] shifted;
    logic [TokW-1:0] mask;
    shifted = keys >> ((lvl * (lvl - 1)) / 2);
    mask    = TokW'((TokW+1)'(1) << lvl) - TokW'(1);
    return shifted[TokW-1:0] & mask;
  endfunction

  // user id of a level (1-based): UidBits wide starting at (lvl-1)*UidBits
  function automatic logic [UidBits-1:0] uid_token(logic [UidW-1:0] uids, int lvl);
    logic [UidW-1:0] shifted;
    shifted = uids >> ((lvl - 1) * UidBits);
    return shifted[UidBits-1:0];
  endfunction

endpackage

@@ design/cpic_lane.sv @@
// one comparison lane: key token difference first, then user id difference
`timescale 1ns / 1ps
module cpic_lane import cpic_pkg::*; (
  input  logic               active_i,
  input  logic [TokW-1:0]    left_key_i,
  input  logic [TokW-1:0]    right_key_i,
  input  logic [UidBits-1:0] left_uid_i,
  input  logic [UidBits-1:0] right_uid_i,
  output cpic_lane_t         lane_o
);

  logic signed [OrderW-1:0] key_diff;
  logic signed [OrderW-1:0] uid_diff;

  // signed differences, left minus right
  assign key_diff = $signed(OrderW'(left_key_i)) - $signed(OrderW'(right_key_i));
  assign uid_diff = $signed(OrderW'(left_uid_i)) - $signed(OrderW'(right_uid_i));

  // key decides when it differs, otherwise the user id
  always_comb begin
    lane_o.hit  = 1'b0;
    lane_o.diff = uid_diff;
    if (active_i) begin
      if (key_diff != '0) begin
        lane_o.hit  = 1'b1;
        lane_o.diff = key_diff;
      end else if (uid_diff != '0) begin
        lane_o.hit  = 1'b1;
        lane_o.diff = uid_diff;
      end
    end
  end

endmodule

@@ design/cpic_merge.sv @@
// merge stage: picks the lowest level that differs, else the depth difference
`timescale 1ns / 1ps
module cpic_merge import cpic_pkg::*; (
  input  cpic_lane_t               lanes_i [MaxLevels],
  input  logic signed [DepthW:0]   depth_diff_i,
  input  logic                     same_i,
  output cpic_res_t                res_o
);

  // priority select, level 1 wins
  always_comb begin
    res_o.order = OrderW'(depth_diff_i);
    res_o.same  = same_i;
    for (int i = MaxLevels - 1; i >= 0; i--) begin
      if (lanes_i[i].hit) begin
        res_o.order = lanes_i[i].diff;
      end
    end
  end

endmodule

@@ design/crdt_position_id_compare_core.sv @@
// top level of the position identifier compare block
// done strobe follows the start edge through the input register (loaded at the
// start edge), then the lane register, then the result register; one transaction every cycle.
// all levels are compared at once in parallel lanes, so the rate is fixed.
// busy_o stays low; reset clears the valid pipeline, no result is pending after it.
`timescale 1ns / 1ps
module crdt_position_id_compare_core import cpic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  cpic_req_t req_i,
  output logic      done_o,
  output cpic_res_t res_o
);

  cpic_req_t              req_q;
  logic                   in_vld_q;
  cpic_lane_t             lanes_d [MaxLevels];
  cpic_lane_t             lanes_q [MaxLevels];
  logic signed [DepthW:0] depth_diff_d, depth_diff_q;
  logic                   same_d, same_q;
  logic                   lane_vld_q;
  cpic_res_t              res_d, res_q;
  logic                   done_q;
  logic [DepthW-1:0]      levels;

  assign busy_o = 1'b0;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      lane_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_vld_q   <= start_i & ~busy_o;
      lane_vld_q <= in_vld_q;
      done_q     <= lane_vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_i;
    lanes_q      <= lanes_d;
    depth_diff_q <= depth_diff_d;
    same_q       <= same_d;
    res_q        <= res_d;
  end

  // number of levels to compare, capped at the word capacity
  always_comb begin
    levels = (req_q.left_depth < req_q.right_depth) ? req_q.left_depth
                                                    : req_q.right_depth;
    if (levels > DepthW'(MaxLevels)) begin
      levels = DepthW'(MaxLevels);
    end
  end

  // fallback order and exact equality
  assign depth_diff_d = $signed({1'b0, req_q.left_depth})
                      - $signed({1'b0, req_q.right_depth});
  assign same_d = (req_q.left_depth == req_q.right_depth)
               && (req_q.left_keys == req_q.right_keys)
               && (req_q.left_uids == req_q.right_uids);

  // one lane per level
  for (genvar g = 0; g < MaxLevels; g++) begin : g_lane
    cpic_lane u_lane (
      .active_i    (DepthW'(g + 1) <= levels),
      .left_key_i  (key_token(req_q.left_keys, g + 1)),
      .right_key_i (key_token(req_q.right_keys, g + 1)),
      .left_uid_i  (uid_token(req_q.left_uids, g + 1)),
      .right_uid_i (uid_token(req_q.right_uids, g + 1)),
      .lane_o      (lanes_d[g])
    );
  end

  // combine lane findings
  cpic_merge u_merge (
    .lanes_i      (lanes_q),
    .depth_diff_i (depth_diff_q),
    .same_i       (same_q),
    .res_o        (res_d)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
